FILE: src/tsp_pkg.sv
// Shared types and constants for the time string parser.
// Holds the input and result beat structs, register indexes and character codes.
// No dependencies.
package tsp_pkg;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_FIXED_WIDTH    = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SEPARATOR_CHAR = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_HAS_SECONDS    = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_HAS_FRACTION   = 8'd3;

	localparam logic       RST_FIXED_WIDTH    = 1'b1;
	localparam logic [7:0] RST_SEPARATOR_CHAR = 8'd58;
	localparam logic       RST_HAS_SECONDS    = 1'b1;
	localparam logic       RST_HAS_FRACTION   = 1'b1;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_DOT  = 8'h2E;

	localparam logic [4:0] POS_MAX     = 5'd31;
	localparam logic [6:0] HOUR_LIMIT  = 7'd24;
	localparam logic [6:0] MINUTE_LIMIT = 7'd60;
	localparam logic [2:0] FRAC_DIGITS = 3'd4;

	typedef struct packed {
		logic [7:0] text_char;
		logic       end_of_string;
	} item_t;

	typedef struct packed {
		logic        time_valid;
		logic [4:0]  hour_value;
		logic [5:0]  minute_value;
		logic [5:0]  second_value;
		logic [13:0] fraction_value;
	} result_t;

endpackage

FILE: src/time_string_parser.sv
// Time string parser top level: input register, one-step parse logic, result register.
// Depends on tsp_pkg for the beat structs, register indexes and character codes.
// Each accepted character is held in the input register and parsed from there; parsing the
// last character of a string also loads the result beat.
// Throughput: one character per cycle; only a last character waits on a stalled result.
// Reset clears the parse state and restores the configuration registers to their defaults.
module time_string_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  tsp_pkg::item_t                item_data,
	output logic                          result_valid,
	input  logic                          result_stall,
	output tsp_pkg::result_t              result_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tsp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tsp_pkg::*;

	typedef enum logic [1:0] {PH_HOUR, PH_MIN, PH_SEC, PH_FRAC} phase_t;

	logic       fixed_q;
	logic [7:0] sep_q;
	logic       has_sec_q;
	logic       has_frac_q;

	logic       valid_s1;
	item_t      item_s1;
	logic       go_s1;

	phase_t      phase_q;
	logic [4:0]  pos_q;
	logic [1:0]  cnt_q;
	logic [6:0]  hour_q;
	logic [6:0]  min_q;
	logic [6:0]  sec_q;
	logic [13:0] frac_q;
	logic [2:0]  widx_q;
	logic        err_q;

	phase_t      n_phase;
	logic [1:0]  n_cnt;
	logic [6:0]  n_hour;
	logic [6:0]  n_min;
	logic [6:0]  n_sec;
	logic [13:0] n_frac;
	logic [2:0]  n_widx;
	logic        n_err;

	logic        out_valid_q;
	result_t     out_q;

	logic [7:0]  c;
	logic        is_dig;
	logic [3:0]  dval;
	logic        sep_on;
	logic        frac_ok;
	logic [4:0]  mpos;
	logic [4:0]  len;
	logic [13:0] frac_term;
	logic [6:0]  field_acc;
	logic [6:0]  field_next;
	logic        may_end;
	logic [7:0]  ender;
	logic        complete;
	logic        ok;
	result_t     res;

	function automatic logic [6:0] acc_step(input logic [6:0] acc, input logic [3:0] d);
		logic [10:0] prod;
		begin
			prod = {4'b0, acc} * 11'd10 + {7'b0, d};
			return prod[6:0];
		end
	endfunction

	assign cfg_ready    = 1'b1;
	assign go_s1        = valid_s1 && (!item_s1.end_of_string || !out_valid_q || !result_stall);
	assign item_stall   = valid_s1 && !go_s1;
	assign result_valid = out_valid_q;
	assign result_data  = out_q;

	assign c       = item_s1.text_char;
	assign is_dig  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	assign dval    = 4'(c - CHAR_ZERO);
	assign sep_on  = sep_q != 8'd0;
	assign frac_ok = has_sec_q && has_frac_q;
	assign mpos    = 5'd2 + {4'b0, sep_on};
	assign len     = 5'd4 + {4'b0, sep_on} + (has_sec_q ? (5'd2 + {4'b0, sep_on}) : 5'd0);

	always_comb begin
		unique case (widx_q)
			3'd0:    frac_term = 14'(dval * 14'd1000);
			3'd1:    frac_term = 14'(dval * 14'd100);
			3'd2:    frac_term = 14'(dval * 14'd10);
			3'd3:    frac_term = {10'b0, dval};
			default: frac_term = 14'd0;
		endcase
	end

	always_comb begin
		unique case (phase_q)
			PH_HOUR: begin
				field_acc = hour_q;
				may_end   = 1'b1;
				ender     = sep_q;
			end
			PH_MIN: begin
				field_acc = min_q;
				may_end   = has_sec_q;
				ender     = sep_q;
			end
			PH_SEC: begin
				field_acc = sec_q;
				may_end   = has_frac_q;
				ender     = CHAR_DOT;
			end
			default: begin
				field_acc = frac_q[6:0];
				may_end   = 1'b0;
				ender     = CHAR_DOT;
			end
		endcase
		field_next = acc_step(field_acc, dval);
	end

	always_comb begin
		n_phase = phase_q;
		n_cnt   = cnt_q;
		n_hour  = hour_q;
		n_min   = min_q;
		n_sec   = sec_q;
		n_frac  = frac_q;
		n_widx  = widx_q;
		n_err   = err_q;
		if (!err_q) begin
			if (fixed_q) begin
				priority if (pos_q < 5'd2) begin
					if (!is_dig) n_err = 1'b1;
					else n_hour = acc_step(hour_q, dval);
				end else if (sep_on && pos_q == 5'd2) begin
					n_err = c != sep_q;
				end else if (pos_q < mpos + 5'd2) begin
					if (!is_dig) n_err = 1'b1;
					else n_min = acc_step(min_q, dval);
				end else if (pos_q < len) begin
					if (sep_on && pos_q == mpos + 5'd2) n_err = c != sep_q;
					else if (!is_dig) n_err = 1'b1;
					else n_sec = acc_step(sec_q, dval);
				end else if (pos_q == len) begin
					n_err = !(frac_ok && c == CHAR_DOT);
				end else if (frac_ok) begin
					if (!is_dig) n_err = 1'b1;
					else if (widx_q < FRAC_DIGITS) begin
						n_frac = frac_q + frac_term;
						n_widx = widx_q + 3'd1;
					end
				end else begin
					n_err = 1'b1;
				end
			end else if (phase_q == PH_FRAC) begin
				if (!is_dig) n_err = 1'b1;
				else if (widx_q < FRAC_DIGITS) begin
					n_frac = frac_q + frac_term;
					n_widx = widx_q + 3'd1;
				end
			end else begin
				priority if (cnt_q < 2'd2 && is_dig) begin
					n_cnt = cnt_q + 2'd1;
					unique case (phase_q)
						PH_HOUR: n_hour = field_next;
						PH_MIN:  n_min  = field_next;
						default: n_sec  = field_next;
					endcase
				end else if (cnt_q != 2'd0 && may_end && c == ender) begin
					n_cnt = 2'd0;
					unique case (phase_q)
						PH_HOUR: n_phase = PH_MIN;
						PH_MIN:  n_phase = PH_SEC;
						default: n_phase = PH_FRAC;
					endcase
				end else begin
					n_err = 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (fixed_q) begin
			complete = ({1'b0, pos_q} + 6'd1) >= {1'b0, len};
		end else begin
			unique case (n_phase)
				PH_MIN:  complete = n_cnt != 2'd0 && !has_sec_q;
				PH_SEC:  complete = n_cnt != 2'd0;
				PH_FRAC: complete = 1'b1;
				default: complete = 1'b0;
			endcase
		end
		ok = !n_err && complete && n_hour < HOUR_LIMIT && n_min < MINUTE_LIMIT
			&& n_sec < MINUTE_LIMIT;
		res.time_valid     = ok;
		res.hour_value     = ok ? n_hour[4:0] : 5'd0;
		res.minute_value   = ok ? n_min[5:0] : 6'd0;
		res.second_value   = ok ? n_sec[5:0] : 6'd0;
		res.fraction_value = ok ? n_frac : 14'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_q     <= RST_FIXED_WIDTH;
			sep_q       <= RST_SEPARATOR_CHAR;
			has_sec_q   <= RST_HAS_SECONDS;
			has_frac_q  <= RST_HAS_FRACTION;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_HOUR;
			pos_q       <= 5'd0;
			cnt_q       <= 2'd0;
			hour_q      <= 7'd0;
			min_q       <= 7'd0;
			sec_q       <= 7'd0;
			frac_q      <= 14'd0;
			widx_q      <= 3'd0;
			err_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_FIXED_WIDTH:    fixed_q    <= cfg_data[0];
					CFG_SEPARATOR_CHAR: sep_q      <= cfg_data;
					CFG_HAS_SECONDS:    has_sec_q  <= cfg_data[0];
					CFG_HAS_FRACTION:   has_frac_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end
			if (go_s1 && item_s1.end_of_string) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (go_s1) begin
				if (item_s1.end_of_string) begin
					phase_q <= PH_HOUR;
					pos_q   <= 5'd0;
					cnt_q   <= 2'd0;
					hour_q  <= 7'd0;
					min_q   <= 7'd0;
					sec_q   <= 7'd0;
					frac_q  <= 14'd0;
					widx_q  <= 3'd0;
					err_q   <= 1'b0;
				end else begin
					phase_q <= n_phase;
					cnt_q   <= n_cnt;
					hour_q  <= n_hour;
					min_q   <= n_min;
					sec_q   <= n_sec;
					frac_q  <= n_frac;
					widx_q  <= n_widx;
					err_q   <= n_err;
					if (pos_q < POS_MAX) begin
						pos_q <= pos_q + 5'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item_data;
		end
		if (go_s1 && item_s1.end_of_string) begin
			out_q <= res;
		end
	end

endmodule

FILE: test/tb_time_string_parser.sv
// Testbench for the time string parser: streams directed and random time strings under
// several register settings and checks every result beat against a cycle-free predictor.
// Depends on tsp_pkg and time_string_parser only.
module tb_time_string_parser;
	import tsp_pkg::*;

	typedef enum logic [1:0] {FIELD_HOUR, FIELD_MINUTE, FIELD_SECOND, FIELD_FRACTION} field_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	item_t                  item_data = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	result_t                result_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic       fixed_mode = RST_FIXED_WIDTH;
	logic [7:0] sep_char = RST_SEPARATOR_CHAR;
	logic       with_seconds = RST_HAS_SECONDS;
	logic       with_fraction = RST_HAS_FRACTION;

	field_t      parse_field = FIELD_HOUR;
	logic [4:0]  char_pos = '0;
	logic [1:0]  digit_count = '0;
	logic [6:0]  hour_acc = '0;
	logic [6:0]  minute_acc = '0;
	logic [6:0]  second_acc = '0;
	logic [13:0] fraction_acc = '0;
	logic [10:0] fraction_weight = 11'd1000;
	logic        parse_failed = 1'b0;

	item_t       pending_chars[$];
	result_t     expected_times[$];
	int unsigned sender_idle_pct = 13;
	int unsigned receiver_idle_pct = 47;
	int unsigned random_items = 0;
	int unsigned mismatch_count = 0;
	int unsigned results_seen = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	time_string_parser dut (
		.clk,
		.arst_n,
		.item_valid,
		.item_stall,
		.item_data,
		.result_valid,
		.result_stall,
		.result_data,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic bit is_numeral(logic [7:0] c);
		return c >= CHAR_ZERO && c <= CHAR_NINE;
	endfunction

	function automatic int frame_length();
		int sep;
		sep = int'(sep_char != 8'd0);
		return 4 + sep + (with_seconds ? 2 + sep : 0);
	endfunction

	task automatic clear_tracker();
		parse_field = FIELD_HOUR;
		char_pos = '0;
		digit_count = '0;
		hour_acc = '0;
		minute_acc = '0;
		second_acc = '0;
		fraction_acc = '0;
		fraction_weight = 11'd1000;
		parse_failed = 1'b0;
	endtask

	task automatic add_digit(inout logic [6:0] acc, input logic [7:0] c);
		if (!is_numeral(c))
			parse_failed = 1'b1;
		else
			acc = 7'(acc * 10 + (c - CHAR_ZERO));
	endtask

	task automatic add_fraction(logic [7:0] c);
		if (!is_numeral(c)) begin
			parse_failed = 1'b1;
		end else if (fraction_weight != 0) begin
			fraction_acc = 14'(fraction_acc + fraction_weight * (c - CHAR_ZERO));
			fraction_weight = 11'(fraction_weight / 10);
		end
	endtask

	task automatic flex_field(inout logic [6:0] acc, input logic [7:0] c, input logic may_end,
			input logic [7:0] ender, input field_t next);
		if (digit_count < 2 && is_numeral(c)) begin
			acc = 7'(acc * 10 + (c - CHAR_ZERO));
			digit_count++;
		end else if (digit_count > 0 && may_end && c == ender) begin
			parse_field = next;
			digit_count = '0;
		end else begin
			parse_failed = 1'b1;
		end
	endtask

	task automatic track_char(item_t it);
		int      sep;
		int      mpos;
		int      len;
		int      p;
		bit      frac_ok;
		bit      ok;
		result_t r;
		sep = int'(sep_char != 8'd0);
		frac_ok = with_seconds && with_fraction;
		mpos = 2 + sep;
		len = frame_length();
		p = int'(char_pos);
		if (!parse_failed) begin
			if (fixed_mode) begin
				if (p < 2)
					add_digit(hour_acc, it.text_char);
				else if (sep && p == 2)
					parse_failed = (it.text_char != sep_char);
				else if (p < mpos + 2)
					add_digit(minute_acc, it.text_char);
				else if (p < len) begin
					if (sep && p == mpos + 2)
						parse_failed = (it.text_char != sep_char);
					else
						add_digit(second_acc, it.text_char);
				end else if (p == len)
					parse_failed = !(frac_ok && it.text_char == CHAR_DOT);
				else if (frac_ok)
					add_fraction(it.text_char);
				else
					parse_failed = 1'b1;
			end else begin
				case (parse_field)
					FIELD_HOUR: begin
						flex_field(hour_acc, it.text_char, 1'b1, sep_char, FIELD_MINUTE);
					end
					FIELD_MINUTE: begin
						flex_field(minute_acc, it.text_char, with_seconds, sep_char,
							FIELD_SECOND);
					end
					FIELD_SECOND: begin
						flex_field(second_acc, it.text_char, with_fraction, CHAR_DOT,
							FIELD_FRACTION);
					end
					default: add_fraction(it.text_char);
				endcase
			end
		end
		if (!it.end_of_string) begin
			if (char_pos != POS_MAX)
				char_pos++;
		end else begin
			ok = !parse_failed;
			if (ok) begin
				if (fixed_mode)
					ok = int'(char_pos) + 1 >= len;
				else if (parse_field == FIELD_MINUTE)
					ok = digit_count > 0 && !with_seconds;
				else if (parse_field == FIELD_SECOND)
					ok = digit_count > 0;
				else
					ok = (parse_field == FIELD_FRACTION);
			end
			ok = ok && hour_acc < HOUR_LIMIT && minute_acc < MINUTE_LIMIT
				&& second_acc < MINUTE_LIMIT;
			r = '0;
			if (ok) begin
				r.time_valid = 1'b1;
				r.hour_value = hour_acc[4:0];
				r.minute_value = minute_acc[5:0];
				r.second_value = second_acc[5:0];
				r.fraction_value = fraction_acc;
			end
			expected_times.push_back(r);
			clear_tracker();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item_data <= '0;
			clear_tracker();
		end else begin
			if (item_valid && !item_stall)
				track_char(item_data);
			if (!item_valid || !item_stall) begin
				if (pending_chars.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					item_valid <= 1'b1;
					item_data <= pending_chars.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_field(string name, logic [13:0] want, logic [13:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_times.size() == 0) begin
					mismatch_count++;
					$display("%0t: result beat expected none, got %p", $time, result_data);
				end else begin
					want = expected_times.pop_front();
					report_field("time_valid", 14'(want.time_valid),
						14'(result_data.time_valid));
					report_field("hour_value", 14'(want.hour_value),
						14'(result_data.hour_value));
					report_field("minute_value", 14'(want.minute_value),
						14'(result_data.minute_value));
					report_field("second_value", 14'(want.second_value),
						14'(result_data.second_value));
					report_field("fraction_value", want.fraction_value,
						result_data.fraction_value);
				end
			end
			if (!hold_done && results_seen >= 40 && pending_chars.size() > 20) begin
				hold_left = 200;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
			end
		end
	end

	task automatic write_beat(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_settings(logic fw, logic [7:0] sep, logic secs, logic frac);
		write_beat(CFG_FIXED_WIDTH, {7'd0, fw});
		write_beat(CFG_SEPARATOR_CHAR, sep);
		write_beat(CFG_HAS_SECONDS, {7'd0, secs});
		write_beat(CFG_HAS_FRACTION, {7'd0, frac});
		cfg_valid <= 1'b0;
		fixed_mode = fw;
		sep_char = sep;
		with_seconds = secs;
		with_fraction = frac;
	endtask

	task automatic settle();
		do @(negedge clk);
		while (pending_chars.size() != 0 || item_valid || expected_times.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_text(string s, bit closes_string);
		item_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.text_char = s[i];
			it.end_of_string = closes_string && i == s.len() - 1;
			pending_chars.push_back(it);
		end
	endtask

	task automatic queue_random_string();
		logic [7:0] text[$];
		item_t      it;
		int         v;
		int         k;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(1, 255)));
		end else begin
			for (int f = 0; f < (with_seconds ? 3 : 2); f++) begin
				if (f > 0 && sep_char != 8'd0)
					text.push_back(sep_char);
				if ($urandom_range(0, 15) == 0)
					v = $urandom_range(0, 99);
				else
					v = $urandom_range(0, f == 0 ? 23 : 59);
				if (fixed_mode || v > 9 || $urandom_range(0, 1))
					text.push_back(8'(CHAR_ZERO + v / 10));
				text.push_back(8'(CHAR_ZERO + v % 10));
			end
			if (with_seconds && with_fraction && $urandom_range(0, 2) != 0) begin
				text.push_back(CHAR_DOT);
				k = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 34) : $urandom_range(0, 6);
				repeat (k) text.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
			end
			case ($urandom_range(0, 11))
				0: text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(1, 255));
				1: if (text.size() > 1) text.pop_back();
				2: text.push_back(8'($urandom_range(1, 255)));
				default: ;
			endcase
		end
		for (int i = 0; i < text.size(); i++) begin
			it.text_char = text[i];
			it.end_of_string = (i == text.size() - 1);
			pending_chars.push_back(it);
		end
		random_items += text.size();
	endtask

	initial begin
		logic [7:0]  sep_pick;
		int unsigned phase_start;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("23:59:59.12345", 1'b1);
		settle();
		// Flexible layout with a dot separator; the fraction is ignored without seconds.
		apply_settings(1'b0, CHAR_DOT, 1'b0, 1'b1);
		send_text("0.0", 1'b1);
		send_text("2.5.", 1'b1);
		send_text("1", 1'b0);
		settle();
		// The open string continues under a fixed layout with no separator.
		apply_settings(1'b1, 8'd0, 1'b0, 1'b0);
		send_text("959", 1'b1);
		settle();
		apply_settings(1'b0, 8'd0, 1'b1, 1'b1);
		send_text("12:3", 1'b1);
		settle();

		while (random_items < 1150) begin
			if (random_items >= 766) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end else if (random_items >= 383) begin
				sender_idle_pct = 47;
				receiver_idle_pct = 13;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: sep_pick = ":";
				5, 6: sep_pick = CHAR_DOT;
				7: sep_pick = 8'd0;
				8: sep_pick = 8'($urandom_range(1, 255));
				default: begin
					sep_pick = $urandom_range(0, 1) ? 8'd255
						: 8'(CHAR_ZERO + $urandom_range(0, 9));
				end
			endcase
			apply_settings(1'($urandom_range(0, 1)), sep_pick, $urandom_range(0, 3) != 0,
				$urandom_range(0, 9) < 7);
			phase_start = random_items;
			while (random_items - phase_start < 90 && random_items < 1150)
				queue_random_string();
			settle();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_times.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#(8 * 400000);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: time_string_parser.f
src/tsp_pkg.sv
src/time_string_parser.sv
test/tb_time_string_parser.sv
